// ===== src/tsr_pkg.sv =====
// Shared constants, codes and interface structs of the sample replay unit.
`default_nettype none
package tsr_pkg;

  localparam int unsigned ROW_DEPTH = 256;
  localparam int unsigned ADDR_W    = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
  localparam int unsigned CNT_W     = $clog2(ROW_DEPTH + 1);

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned STAT_W    = 8;
  // row word, lowest bits first: pos_x, pos_y, vel_x, vel_y, status
  localparam int unsigned ROW_W     = 4 * VAL_W + STAT_W;
  localparam int unsigned IN_DATA_W = TIME_W + ROW_W;

  localparam int unsigned TOL_W     = 10;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

  // APB register map: byte address 4 * index, index taken from paddr[2]
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam logic REG_TOLERANCE    = 1'b0;

  typedef enum logic [1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_LOAD    = 2'd1,
    FUNC_RESTART = 2'd2,
    FUNC_POLL    = 2'd3
  } func_e;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] wdata;
  } time_req_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [ROW_W-1:0]  wdata;
  } row_req_t;

  typedef struct packed {
    logic valid;
    logic emitted;
    logic exhausted;
    logic load_error;
  } res_t;

endpackage
`default_nettype wire

// ===== src/tsr_ram.sv =====
// Single-port synchronous RAM with registered read data.
`default_nettype none
module tsr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== src/tsr_ctrl.sv =====
// Request sequencer: load, clear, restart and poll walk over the row memories.
`default_nettype none
module tsr_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire tsr_pkg::func_e                in_func_i,
  input  wire logic [tsr_pkg::TIME_W-1:0]    in_time_i,
  input  wire logic [tsr_pkg::ROW_W-1:0]     in_row_i,
  input  wire logic [tsr_pkg::TOL_W-1:0]     tol_i,
  input  wire logic                          out_free_i,
  input  wire logic [tsr_pkg::TIME_W-1:0]    time_rdata_i,
  output tsr_pkg::time_req_t                 time_req_o,
  output tsr_pkg::row_req_t                  row_req_o,
  output tsr_pkg::res_t                      res_o
);

  localparam int unsigned LIM_W   = tsr_pkg::TIME_W + 2;
  localparam int unsigned STATE_W = 3;
  localparam logic [STATE_W-1:0] ST_IDLE   = 3'd0;
  localparam logic [STATE_W-1:0] ST_EXEC   = 3'd1;
  localparam logic [STATE_W-1:0] ST_READ   = 3'd2;
  localparam logic [STATE_W-1:0] ST_CMP    = 3'd3;
  localparam logic [STATE_W-1:0] ST_REPORT = 3'd4;
  localparam logic [STATE_W-1:0] ST_OUT    = 3'd5;

  logic [STATE_W-1:0]              state_q, state_d;
  tsr_pkg::func_e                  func_q, func_d;
  logic [tsr_pkg::TIME_W-1:0]      time_q, time_d;
  logic [tsr_pkg::ROW_W-1:0]       row_q, row_d;
  logic [tsr_pkg::CNT_W-1:0]       count_q, count_d;
  logic [tsr_pkg::CNT_W-1:0]       next_q, next_d;
  logic [tsr_pkg::TIME_W-1:0]      start_q, start_d;
  logic                            start_vld_q, start_vld_d;
  logic                            ever_q, ever_d;
  logic                            done_q, done_d;
  logic [tsr_pkg::TIME_W-1:0]      first_q, first_d;
  logic [tsr_pkg::TIME_W-1:0]      prev_q, prev_d;
  logic                            failed_q, failed_d;
  logic [LIM_W-1:0]                limit_q, limit_d;
  logic                            adv_q, adv_d;
  logic                            emit_q, emit_d;

  logic [tsr_pkg::CNT_W-1:0]       next_inc;
  logic [tsr_pkg::CNT_W-1:0]       next_dec;
  logic [tsr_pkg::TIME_W-1:0]      start_eff;
  logic [tsr_pkg::TIME_W-1:0]      base_time;
  logic                            row_passes;

  assign next_inc   = next_q + 1'b1;
  assign next_dec   = next_q - 1'b1;
  assign start_eff  = start_vld_q ? start_q : time_q;
  assign base_time  = (count_q == '0) ? time_q : first_q;
  // limit may be negative when now is below the latched start
  assign row_passes = $signed({2'b00, time_rdata_i}) <= $signed(limit_q);

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    time_d      = time_q;
    row_d       = row_q;
    count_d     = count_q;
    next_d      = next_q;
    start_d     = start_q;
    start_vld_d = start_vld_q;
    ever_d      = ever_q;
    done_d      = done_q;
    first_d     = first_q;
    prev_d      = prev_q;
    failed_d    = failed_q;
    limit_d     = limit_q;
    adv_d       = adv_q;
    emit_d      = emit_q;
    time_req_o  = '0;
    row_req_o   = '0;
    res_o       = '0;
    in_ready_o  = (state_q == ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          func_d  = in_func_i;
          time_d  = in_time_i;
          row_d   = in_row_i;
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        emit_d  = 1'b0;
        state_d = ST_OUT;
        unique case (func_q)
          tsr_pkg::FUNC_CLEAR: begin
            count_d     = '0;
            failed_d    = 1'b0;
            next_d      = '0;
            start_vld_d = 1'b0;
            ever_d      = 1'b0;
            done_d      = 1'b0;
          end
          tsr_pkg::FUNC_LOAD: begin
            if (!failed_q) begin
              if (count_q == tsr_pkg::CNT_W'(tsr_pkg::ROW_DEPTH)) begin
                count_d  = '0;
                failed_d = 1'b1;
              end else if (count_q != '0 && time_q < prev_q) begin
                count_d  = '0;
                failed_d = 1'b1;
              end else begin
                first_d          = base_time;
                prev_d           = time_q;
                time_req_o.we    = 1'b1;
                time_req_o.addr  = count_q[tsr_pkg::ADDR_W-1:0];
                time_req_o.wdata = time_q - base_time;
                row_req_o.we     = 1'b1;
                row_req_o.addr   = count_q[tsr_pkg::ADDR_W-1:0];
                row_req_o.wdata  = row_q;
                count_d          = count_q + 1'b1;
              end
            end
          end
          tsr_pkg::FUNC_RESTART: begin
            next_d      = '0;
            start_vld_d = 1'b0;
            ever_d      = 1'b0;
            done_d      = 1'b0;
          end
          tsr_pkg::FUNC_POLL: begin
            if (count_q == '0) begin
              done_d = 1'b1;
            end else begin
              start_d     = start_eff;
              start_vld_d = 1'b1;
              limit_d     = {2'b00, time_q} - {2'b00, start_eff} + LIM_W'(tol_i);
              adv_d       = 1'b0;
              state_d     = ST_READ;
            end
          end
        endcase
      end

      ST_READ: begin
        if (next_q < count_q) begin
          time_req_o.re   = 1'b1;
          time_req_o.addr = next_q[tsr_pkg::ADDR_W-1:0];
          state_d         = ST_CMP;
        end else begin
          state_d = ST_REPORT;
        end
      end

      ST_CMP: begin
        if (row_passes) begin
          next_d = next_inc;
          adv_d  = 1'b1;
          if (next_inc < count_q) begin
            // fetch the following row while this one retires
            time_req_o.re   = 1'b1;
            time_req_o.addr = next_inc[tsr_pkg::ADDR_W-1:0];
          end else begin
            state_d = ST_REPORT;
          end
        end else begin
          state_d = ST_REPORT;
        end
      end

      ST_REPORT: begin
        state_d = ST_OUT;
        if ((!adv_q && ever_q) || next_q == '0) begin
          emit_d = 1'b0;
        end else begin
          emit_d         = 1'b1;
          ever_d         = 1'b1;
          row_req_o.re   = 1'b1;
          row_req_o.addr = next_dec[tsr_pkg::ADDR_W-1:0];
          if (next_q >= count_q) begin
            done_d = 1'b1;
          end
        end
      end

      ST_OUT: begin
        if (out_free_i) begin
          res_o.valid      = 1'b1;
          res_o.emitted    = emit_q;
          res_o.exhausted  = done_q;
          res_o.load_error = failed_q;
          state_d          = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      next_q      <= '0;
      start_q     <= '0;
      start_vld_q <= 1'b0;
      ever_q      <= 1'b0;
      done_q      <= 1'b0;
      first_q     <= '0;
      prev_q      <= '0;
      failed_q    <= 1'b0;
      adv_q       <= 1'b0;
      emit_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      next_q      <= next_d;
      start_q     <= start_d;
      start_vld_q <= start_vld_d;
      ever_q      <= ever_d;
      done_q      <= done_d;
      first_q     <= first_d;
      prev_q      <= prev_d;
      failed_q    <= failed_d;
      adv_q       <= adv_d;
      emit_q      <= emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    time_q  <= time_d;
    row_q   <= row_d;
    limit_q <= limit_d;
  end

endmodule
`default_nettype wire

// ===== src/timestamped_sample_replay_unit.sv =====
// Top level of the timestamped sample replay unit: stream ports, APB register, row memories.
`default_nettype none
// Stores up to ROW_DEPTH (256) timestamped sample rows and replays them against polled time.
// Every request on the input stream yields exactly one result on the output stream. The
// request code travels in s_axis_tuser: clear, load row, restart playback, poll. Row times
// are rebased to the first loaded row; an out-of-order row or a load into a full store
// empties the store and raises load_error until the next clear. A poll latches its time as
// the start on the first poll of a non-empty store after a clear or restart, then steps past
// every row whose rebased time is within (now - start + tolerance_us) and reports the last
// row passed, if any. Clear, load, restart and a poll of an empty store pass the execute and
// output steps to reach the result register; any other poll also compares each row passed,
// plus the first row that does not pass if there is one, in read and compare steps: the time
// memory is read one row per cycle and each read is compared the cycle after. One request is
// in work at a time; the next can be accepted in the cycle after the result register loads,
// even while that result still waits there. The row memories need no clearing pass: only
// entries below the row count are ever read.
// tolerance_us sits at APB byte address 0 (reset 1) and should only be written while idle.
module timestamped_sample_replay_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // request stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata, low bit up: time_us[31:0], pos_x, pos_y, vel_x, vel_y, status_in[7:0]
  input  wire logic [tsr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: func[1:0]
  input  wire logic [1:0]                        s_axis_tuser,
  // result stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // tdata, low bit up: pos_x_out, pos_y_out, vel_x_out, vel_y_out, status_out[7:0]
  output logic      [tsr_pkg::ROW_W-1:0]         m_axis_tdata,
  // tuser, low bit up: emitted, exhausted, load_error
  output logic      [2:0]                        m_axis_tuser,
  // APB register port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [tsr_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [tsr_pkg::PDATA_W-1:0]       pwdata,
  output logic      [tsr_pkg::PDATA_W-1:0]       prdata,
  output logic                                   pready
);

  tsr_pkg::time_req_t               time_req;
  tsr_pkg::row_req_t                row_req;
  tsr_pkg::res_t                    res;
  logic [tsr_pkg::TIME_W-1:0]       time_rdata;
  logic [tsr_pkg::ROW_W-1:0]        row_rdata;

  logic [tsr_pkg::TOL_W-1:0]        tol_q, tol_d;
  logic                             out_valid_q, out_valid_d;
  logic [tsr_pkg::ROW_W-1:0]        out_data_q, out_data_d;
  logic [2:0]                       out_user_q, out_user_d;
  logic                             out_free;
  logic                             reg_is_tol;

  // ---- configuration register ----
  assign pready     = 1'b1;
  assign reg_is_tol = (paddr[2] == tsr_pkg::REG_TOLERANCE);
  assign prdata     = reg_is_tol ? tsr_pkg::PDATA_W'(tol_q) : '0;

  always_comb begin
    tol_d = tol_q;
    if (psel && penable && pwrite && pready && reg_is_tol) begin
      tol_d = pwdata[tsr_pkg::TOL_W-1:0];
    end
  end

  // ---- row memories: rebased times, and the packed value/status word ----
  tsr_ram #(
    .WIDTH (tsr_pkg::TIME_W),
    .DEPTH (tsr_pkg::ROW_DEPTH),
    .AW    (tsr_pkg::ADDR_W)
  ) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (time_req.we),
    .re_i    (time_req.re),
    .addr_i  (time_req.addr),
    .wdata_i (time_req.wdata),
    .rdata_o (time_rdata)
  );

  tsr_ram #(
    .WIDTH (tsr_pkg::ROW_W),
    .DEPTH (tsr_pkg::ROW_DEPTH),
    .AW    (tsr_pkg::ADDR_W)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_req.we),
    .re_i    (row_req.re),
    .addr_i  (row_req.addr),
    .wdata_i (row_req.wdata),
    .rdata_o (row_rdata)
  );

  // ---- sequencer ----
  tsr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_func_i    (tsr_pkg::func_e'(s_axis_tuser)),
    .in_time_i    (s_axis_tdata[tsr_pkg::TIME_W-1:0]),
    .in_row_i     (s_axis_tdata[tsr_pkg::IN_DATA_W-1:tsr_pkg::TIME_W]),
    .tol_i        (tol_q),
    .out_free_i   (out_free),
    .time_rdata_i (time_rdata),
    .time_req_o   (time_req),
    .row_req_o    (row_req),
    .res_o        (res)
  );

  // ---- result register ----
  // The row word is valid here: it was read in the report step, and
  // the row memory holds its read data until the next read.
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
      out_data_d  = res.emitted ? row_rdata : '0;
      out_user_d  = {res.load_error, res.exhausted, res.emitted};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q       <= tsr_pkg::TOL_RESET;
      out_valid_q <= 1'b0;
    end else begin
      tol_q       <= tol_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // ---- checks ----
  // the sequencer only hands over a result when the result register can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> (!out_valid_q || m_axis_tready))
    else $error("result handed over while result register is stalled");

  // a failed load leaves the store empty, so nothing can be reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> !m_axis_tuser[2])
    else $error("row reported while load error is set");

  // one request at a time: the input closes right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while sequencer busy");

endmodule
`default_nettype wire
